>>> src/schrb_pkg.sv
package schrb_pkg;

    localparam int DEF_MAX_BASIS = 4096;
    localparam int DEF_MAX_SITES = 64;

    localparam int WORD_W  = 64;
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 13;
    localparam int LEN_W   = 7;
    localparam int SITE_W  = 6;
    localparam int LL_W    = 13;
    localparam int DEN_W   = 15;
    localparam int ACC_W   = 64;
    localparam int SQ_SUM_W = 18;
    localparam int LIN_SUM_W = 12;
    localparam int PAIR_SUM_W = 8;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = VAL_W + MUL_B_W;

    localparam logic [2:0] REG_COUPLING_J    = 3'd0;
    localparam logic [2:0] REG_INTERACTION_V = 3'd1;
    localparam logic [2:0] REG_FIELD_GAMMA   = 3'd2;
    localparam logic [2:0] REG_CURV_ALPHA    = 3'd3;
    localparam logic [2:0] REG_NUM_SITES     = 3'd4;
    localparam logic [2:0] REG_BASIS_COUNT   = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SITE,
        ST_SRCH,
        ST_SCMP,
        ST_EMIT,
        ST_MUL,
        ST_DIV
    } state_t;

endpackage

>>> src/schrb_div.sv
module schrb_div
    import schrb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic signed [VAL_W-1:0] quotient
);

    logic [ACC_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [6:0]       cnt_reg;

    logic [ACC_W-1:0] mag;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    // floor for negative dividends: -floor((-n + d - 1) / d)
    assign mag = dividend[ACC_W-1]
                 ? (ACC_W'(-dividend) + ACC_W'(divisor) - ACC_W'(1))
                 : ACC_W'(dividend);
    assign rem_sh = {rem_reg, q_reg[ACC_W-1]};
    assign fits = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[ACC_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[ACC_W-2:0], fits};
        end
    end

    always_comb
    begin
        priority if (!neg_reg && q_reg > ACC_W'(32'h7FFF_FFFF))
            quotient = 32'sh7FFF_FFFF;
        else if (neg_reg && q_reg > ACC_W'(33'h0_8000_0000))
            quotient = -32'sh7FFF_FFFF - 32'sd1;
        else if (neg_reg)
            quotient = -$signed(q_reg[VAL_W-1:0]);
        else
            quotient = $signed(q_reg[VAL_W-1:0]);
    end

    assign done = done_reg;

endmodule

>>> src/spin_chain_hamiltonian_row_builder_unit.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser: op; tdata: basis_word, entry_index
// m_axis    out  tdata: row, column, value; tuser: found; tlast: last
// cfg       in   cfg_index selects register, cfg_data is the value
//
// A row reads its basis word, walks the L sites and binary-searches the table
// for each hop (a read state and a compare state per probe, about log2(count)
// probes), then runs the multiply steps and the serial divide. Each hop and the
// diagonal give one result beat. The table has a single read port.
// Reset initialises control state and config registers; the table holds rubbish until
// written. A stalled m_axis beat holds the unit until taken.
module spin_chain_hamiltonian_row_builder_unit
    import schrb_pkg::*;
#(
    parameter int MAX_BASIS = DEF_MAX_BASIS,
    parameter int MAX_SITES = DEF_MAX_SITES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // basis_word[63:0], entry_index[75:64]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // row[11:0], column[23:12], value[55:24]
    output logic        m_axis_tuser,   // found
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(MAX_BASIS);
    localparam int CW = $clog2(MAX_BASIS + 1);

    state_t state_reg, state_next;

    logic signed [VAL_W-1:0] j_reg, v_reg, gamma_reg, alpha_reg;
    logic [LEN_W-1:0]        sites_reg;
    logic [CNT_W-1:0]        bcount_reg;

    logic [WORD_W-1:0] mem [MAX_BASIS];
    logic [WORD_W-1:0] rdata_reg;
    logic [AW-1:0]     rd_addr;

    logic [IDX_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LL_W-1:0]   ll_reg;
    logic [CW-1:0]     count_reg;
    logic signed [VAL_W-1:0] hop_reg;
    logic [WORD_W-1:0] bits_reg;
    logic [WORD_W-1:0] target_reg;
    logic [SITE_W-1:0] s_reg;
    logic signed [SQ_SUM_W-1:0]   sq_sum_reg;
    logic signed [LIN_SUM_W-1:0]  lin_sum_reg;
    logic signed [PAIR_SUM_W-1:0] pair_sum_reg;
    logic [CW-1:0]     lo_reg, hi_reg;
    logic [AW-1:0]     mid_reg;
    logic [2:0]        mcnt_reg;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_B_W-1:0] t_reg, q_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic [IDX_W-1:0]        o_row_reg, o_col_reg;
    logic signed [VAL_W-1:0] o_val_reg;
    logic                    o_found_reg, o_last_reg;

    logic [IDX_W-1:0]  in_idx;
    logic [CW-1:0]     count_eff;
    logic [LEN_W-1:0]  len_eff;
    logic [CW:0]       mid_sum;
    logic [AW-1:0]     mid;
    logic              b0, b1, last_site;
    logic [SITE_W-1:0] s_up;
    logic [11:0]       sq;
    logic signed [VAL_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [VAL_W:0]     j_inc;
    logic                      div_start;
    logic                      div_done;
    logic signed [VAL_W-1:0]   div_q;
    logic                      in_acc;

    assign in_idx    = s_axis_tdata[75:64];
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign count_eff = (32'(bcount_reg) > 32'(MAX_BASIS)) ? CW'(MAX_BASIS) : CW'(bcount_reg);
    assign len_eff   = (sites_reg < LEN_W'(2)) ? LEN_W'(2)
                     : (32'(sites_reg) > 32'(MAX_SITES)) ? LEN_W'(MAX_SITES) : sites_reg;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[AW:1];
    assign b0        = bits_reg[s_reg];
    assign s_up      = s_reg + SITE_W'(1);
    assign b1        = bits_reg[s_up];
    assign last_site = LEN_W'(s_reg) == len_reg - LEN_W'(1);
    assign sq        = 12'(s_reg) * 12'(s_reg);
    assign j_inc     = {j_reg[VAL_W-1], j_reg} + (VAL_W+1)'(1);

    assign s_axis_tready = state_reg == ST_IDLE;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = state_reg == ST_EMIT;
    assign m_axis_tdata  = {o_val_reg, o_col_reg, o_row_reg};
    assign m_axis_tuser  = o_found_reg;
    assign m_axis_tlast  = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg      <= '0;
            v_reg      <= '0;
            gamma_reg  <= '0;
            alpha_reg  <= '0;
            sites_reg  <= LEN_W'(16);
            bcount_reg <= CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COUPLING_J:    j_reg      <= $signed(cfg_data);
                REG_INTERACTION_V: v_reg      <= $signed(cfg_data);
                REG_FIELD_GAMMA:   gamma_reg  <= $signed(cfg_data);
                REG_CURV_ALPHA:    alpha_reg  <= $signed(cfg_data);
                REG_NUM_SITES:     sites_reg  <= cfg_data[LEN_W-1:0];
                REG_BASIS_COUNT:   bcount_reg <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // basis table
    always_comb
    begin
        priority if (state_reg == ST_IDLE)
            rd_addr = AW'(in_idx);
        else
            rd_addr = mid;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tuser == OP_LOAD && 32'(in_idx) < 32'(MAX_BASIS))
            mem[AW'(in_idx)] <= s_axis_tdata[63:0];
        rdata_reg <= mem[rd_addr];
    end

    // shared multiplier
    always_comb
    begin
        unique case (mcnt_reg)
            3'd0:    begin mul_a = VAL_W'(signed'({1'b0, ll_reg})); mul_b = MUL_B_W'(lin_sum_reg); end
            3'd1:    begin mul_a = VAL_W'(signed'({1'b0, ll_reg})); mul_b = MUL_B_W'(pair_sum_reg); end
            3'd2:    begin mul_a = alpha_reg; mul_b = MUL_B_W'(sq_sum_reg); end
            3'd3:    begin mul_a = gamma_reg; mul_b = t_reg; end
            default: begin mul_a = v_reg;     mul_b = q_reg; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && s_axis_tuser == OP_ROW && 32'(in_idx) < 32'(count_eff))
                    state_next = ST_RD;
            ST_RD:
                state_next = ST_SITE;
            ST_SITE:
                priority if (last_site)
                    state_next = ST_MUL;
                else if (b0 != b1)
                    state_next = ST_SRCH;
            ST_SRCH:
                state_next = (lo_reg < hi_reg) ? ST_SCMP : ST_EMIT;
            ST_SCMP:
                state_next = (rdata_reg == target_reg) ? ST_EMIT : ST_SRCH;
            ST_EMIT:
                if (m_axis_tready)
                    state_next = o_last_reg ? ST_IDLE : ST_SITE;
            ST_MUL:
                // start once the last product has landed in the accumulator
                if (mcnt_reg == 3'd6)
                begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end
            ST_DIV:
                if (div_done)
                    state_next = ST_EMIT;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_reg      <= in_idx;
                len_reg      <= len_eff;
                ll_reg       <= LL_W'(len_eff * len_eff);
                count_reg    <= count_eff;
                hop_reg      <= j_inc[VAL_W:1];
                s_reg        <= '0;
                sq_sum_reg   <= '0;
                lin_sum_reg  <= '0;
                pair_sum_reg <= '0;
                mcnt_reg     <= '0;
            end
            ST_RD:
                bits_reg <= rdata_reg;
            ST_SITE:
            begin
                sq_sum_reg  <= b0 ? sq_sum_reg + SQ_SUM_W'(sq) : sq_sum_reg - SQ_SUM_W'(sq);
                lin_sum_reg <= b0 ? lin_sum_reg + LIN_SUM_W'(s_reg)
                                  : lin_sum_reg - LIN_SUM_W'(s_reg);
                if (!last_site)
                begin
                    pair_sum_reg <= (b0 == b1) ? pair_sum_reg + PAIR_SUM_W'(1)
                                               : pair_sum_reg - PAIR_SUM_W'(1);
                    s_reg        <= s_up;
                end
                target_reg <= bits_reg ^ (WORD_W'(3) << s_reg);
                lo_reg     <= '0;
                hi_reg     <= count_reg;
            end
            ST_SRCH:
            begin
                mid_reg     <= mid;
                o_row_reg   <= idx_reg;
                o_col_reg   <= '0;
                o_val_reg   <= hop_reg;
                o_found_reg <= 1'b0;
                o_last_reg  <= 1'b0;
            end
            ST_SCMP:
                priority if (rdata_reg == target_reg)
                begin
                    o_col_reg   <= IDX_W'(mid_reg);
                    o_found_reg <= 1'b1;
                end
                else if (rdata_reg < target_reg)
                    lo_reg <= CW'(mid_reg) + CW'(1);
                else
                    hi_reg <= CW'(mid_reg);
            ST_MUL:
            begin
                mcnt_reg <= mcnt_reg + 3'd1;
                prod_reg <= mul_p;
                unique case (mcnt_reg)
                    3'd1:    t_reg   <= prod_reg[MUL_B_W-1:0];
                    3'd2:    q_reg   <= prod_reg[MUL_B_W-1:0];
                    3'd3:    acc_reg <= ACC_W'(prod_reg) <<< 1;
                    3'd4:    acc_reg <= acc_reg - (ACC_W'(prod_reg) <<< 1);
                    3'd5:    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                o_row_reg   <= idx_reg;
                o_col_reg   <= idx_reg;
                o_val_reg   <= div_q;
                o_found_reg <= 1'b1;
                o_last_reg  <= 1'b1;
            end
            default: ;
        endcase
    end

    schrb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg + ACC_W'({ll_reg, 1'b0})),
        .divisor  (DEN_W'({ll_reg, 2'b00})),
        .done     (div_done),
        .quotient (div_q)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide phase");

    a_row_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not idle after row end");

    a_last_is_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("diagonal beat without found flag");

endmodule
